/* rtl/ddo_pkg.sv */
// Shared types and constants for the differential drive odometry block.
// Holds the arctangent table, register indexes, reset values and the
// controller-to-datapath command bundle. No dependencies.
`default_nettype none

package ddo_pkg;

    localparam int ATAN_ENTRIES = 30;
    localparam int ATAN_IDX_W   = 5;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_SCALE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_SCALE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADING_GAIN = 2'd2;

    localparam logic [31:0] SCALE_RESET   = 32'h0001_0000;
    localparam logic [31:0] HEADING_RESET = 32'hC000_0000;
    localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN     = 32'h8000_0000;
    localparam logic signed [31:0] CORDIC_SEED = 32'sd652032874;
    localparam logic [61:0] ROUND_INC     = 62'h2000_0000;

    typedef enum logic [2:0] {
        OP_DL  = 3'd0,
        OP_DR  = 3'd1,
        OP_TLO = 3'd2,
        OP_THI = 3'd3,
        OP_XLO = 3'd4,
        OP_XHI = 3'd5,
        OP_YLO = 3'd6,
        OP_YHI = 3'd7
    } op_t;

    typedef struct packed {
        logic                  load;
        logic                  reinit;
        logic                  rot_load;
        logic                  rot_step;
        logic [ATAN_IDX_W-1:0] rot_idx;
        logic                  rot_fix;
        logic                  mul_issue;
        logic                  mul_acc;
        op_t                   op;
    } ddo_cmd_t;

    function automatic logic [31:0] atan_bau(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051E;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2F9;
            5'd15:   r = 32'h0000_517D;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A30;
            5'd19:   r = 32'h0000_0518;
            5'd20:   r = 32'h0000_028C;
            5'd21:   r = 32'h0000_0146;
            5'd22:   r = 32'h0000_00A3;
            5'd23:   r = 32'h0000_0051;
            5'd24:   r = 32'h0000_0029;
            5'd25:   r = 32'h0000_0014;
            5'd26:   r = 32'h0000_000A;
            5'd27:   r = 32'h0000_0005;
            5'd28:   r = 32'h0000_0003;
            5'd29:   r = 32'h0000_0001;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/differential_drive_odometry.sv */
// Differential drive odometry, top level. Update request: CORDIC_STEPS
// rotation steps, then eight issue/accumulate passes of the shared 33x33
// multiplier, then the result is held until taken; no new request is
// accepted until then. Reinit request: result valid in the cycle after
// accept. Reset (rst_n low, async) restores the origin pose with heading
// -pi/2 and unit scale and gain registers.
`default_nettype none

module differential_drive_odometry #(
    parameter int CORDIC_STEPS           = 16,
    parameter int POSITION_FRACTION_BITS = 8
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              command,
    input  wire  signed [15:0]               left_ticks,
    input  wire  signed [15:0]               right_ticks,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic signed [31:0]               pose_x,
    output logic signed [31:0]               pose_y,
    output logic signed [31:0]               pose_heading,
    input  wire                              cfg_we,
    input  wire  [ddo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [31:0]                      cfg_data
);

    ddo_pkg::ddo_cmd_t cmd;

    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ddo_datapath #(
        .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_ticks   (left_ticks),
        .right_ticks  (right_ticks),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading)
    );

endmodule

`default_nettype wire

/* rtl/ddo_ctrl.sv */
// Sequencer for the odometry update: rotation steps, then eight multiply
// operations of issue and accumulate, then the result hold (reinit: straight to hold).
// Depends on ddo_pkg for the command bundle and operation codes.
`default_nettype none

module ddo_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire              command,
    output logic             out_valid,
    input  wire              out_ready,
    output ddo_pkg::ddo_cmd_t cmd
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ROT  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ddo_pkg::op_t      op_reg, op_next;
    logic              phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        phase_next = phase_reg;

        cmd           = '0;
        cmd.op        = op_reg;
        cmd.rot_idx   = ddo_pkg::ATAN_IDX_W'(step_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (command)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.rot_load = 1'b1;
                        step_next    = '0;
                        state_next   = ST_ROT;
                    end
                end
            end
            ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_MUL;
                    op_next    = ddo_pkg::OP_DL;
                    phase_next = 1'b0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                if (!phase_reg)
                begin
                    cmd.mul_issue = 1'b1;
                    cmd.rot_fix   = (op_reg == ddo_pkg::OP_DL);
                    phase_next    = 1'b1;
                end
                else
                begin
                    cmd.mul_acc = 1'b1;
                    phase_next  = 1'b0;
                    if (op_reg == ddo_pkg::OP_YHI)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        op_next = ddo_pkg::op_t'(op_reg + 3'd1);
                    end
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            op_reg    <= ddo_pkg::OP_DL;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

`default_nettype wire

/* rtl/ddo_datapath.sv */
// Datapath: configuration registers, pose state, shift-add rotation unit
// and one shared signed multiplier with its accumulators.
// Depends on ddo_pkg; driven by commands from ddo_ctrl.
`default_nettype none

module ddo_datapath #(
    parameter int POSITION_FRACTION_BITS = 8
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  ddo_pkg::ddo_cmd_t                    cmd,
    input  wire                                  cfg_we,
    input  wire  [ddo_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [31:0]                          cfg_data,
    input  wire  signed [15:0]                   left_ticks,
    input  wire  signed [15:0]                   right_ticks,
    output logic signed [31:0]                   pose_x,
    output logic signed [31:0]                   pose_y,
    output logic signed [31:0]                   pose_heading
);

    localparam int SH = 17 - POSITION_FRACTION_BITS;
    localparam logic signed [49:0] RND = 50'sd1 <<< (SH - 1);

    logic [31:0] lts_reg, lts_next;
    logic [31:0] rts_reg, rts_next;
    logic [31:0] hg_reg, hg_next;
    logic [31:0] pos_x_reg, pos_x_next;
    logic [31:0] pos_y_reg, pos_y_next;
    logic [31:0] head_reg, head_next;

    logic signed [15:0] left_reg, left_next;
    logic signed [15:0] right_reg, right_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic signed [31:0] cos_reg, cos_next;
    logic signed [31:0] sin_reg, sin_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [49:0] dl_reg, dl_next;
    logic signed [49:0] sum_reg, sum_next;
    logic signed [49:0] diff_reg, diff_next;
    logic signed [49:0] travel_reg, travel_next;
    logic [31:0]        turn_reg, turn_next;
    logic [61:0]        acc_reg, acc_next;

    logic signed [31:0] xs, ys;
    logic signed [32:0] at;
    logic [31:0]        ang_plus;
    logic               flip_new;
    logic signed [32:0] mul_a, mul_b;
    logic signed [49:0] prod_lo;

    // rotation unit
    always_comb
    begin
        xs       = x_reg >>> cmd.rot_idx;
        ys       = y_reg >>> cmd.rot_idx;
        at       = $signed({1'b0, ddo_pkg::atan_bau(cmd.rot_idx)});
        ang_plus = head_reg + ddo_pkg::QUARTER_TURN;
        flip_new = ang_plus[31];

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;

        if (cmd.rot_load)
        begin
            x_next    = ddo_pkg::CORDIC_SEED;
            y_next    = '0;
            flip_next = flip_new;
            z_next    = 33'($signed(flip_new ? (head_reg ^ ddo_pkg::HALF_TURN) : head_reg));
        end
        else if (cmd.rot_step)
        begin
            if (!z_reg[32])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
        end

        if (cmd.rot_fix)
        begin
            cos_next = flip_reg ? -x_reg : x_reg;
            sin_next = flip_reg ? -y_reg : y_reg;
        end
    end

    // multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            ddo_pkg::OP_DL:
            begin
                mul_a = -(33'(left_reg));
                mul_b = $signed({1'b0, lts_reg});
            end
            ddo_pkg::OP_DR:
            begin
                mul_a = 33'(right_reg);
                mul_b = $signed({1'b0, rts_reg});
            end
            ddo_pkg::OP_TLO:
            begin
                mul_a = $signed({1'b0, diff_reg[31:0]});
                mul_b = $signed({1'b0, hg_reg});
            end
            ddo_pkg::OP_THI:
            begin
                mul_a = 33'($signed(diff_reg[49:32]));
                mul_b = $signed({1'b0, hg_reg});
            end
            ddo_pkg::OP_XLO:
            begin
                mul_a = $signed({1'b0, travel_reg[31:0]});
                mul_b = 33'(cos_reg);
            end
            ddo_pkg::OP_XHI:
            begin
                mul_a = 33'($signed(travel_reg[49:32]));
                mul_b = 33'(cos_reg);
            end
            ddo_pkg::OP_YLO:
            begin
                mul_a = $signed({1'b0, travel_reg[31:0]});
                mul_b = 33'(sin_reg);
            end
            ddo_pkg::OP_YHI:
            begin
                mul_a = 33'($signed(travel_reg[49:32]));
                mul_b = 33'(sin_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // accumulate, pose and configuration
    always_comb
    begin
        prod_next   = cmd.mul_issue ? (mul_a * mul_b) : prod_reg;
        prod_lo     = $signed(prod_reg[49:0]);
        dl_next     = dl_reg;
        sum_next    = sum_reg;
        diff_next   = diff_reg;
        travel_next = travel_reg;
        turn_next   = turn_reg;
        acc_next    = acc_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        head_next   = head_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        lts_next    = lts_reg;
        rts_next    = rts_reg;
        hg_next     = hg_reg;

        if (cmd.load)
        begin
            left_next  = left_ticks;
            right_next = right_ticks;
        end

        if (cmd.reinit)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            head_next  = ddo_pkg::HEADING_RESET;
        end

        if (cmd.mul_acc)
        begin
            unique case (cmd.op)
                ddo_pkg::OP_DL:
                begin
                    dl_next = prod_lo;
                end
                ddo_pkg::OP_DR:
                begin
                    sum_next  = dl_reg + prod_lo;
                    diff_next = prod_lo - dl_reg;
                end
                ddo_pkg::OP_TLO:
                begin
                    turn_next   = prod_reg[63:32];
                    travel_next = (sum_reg + RND) >>> SH;
                end
                ddo_pkg::OP_THI:
                begin
                    turn_next = turn_reg + prod_reg[31:0];
                end
                ddo_pkg::OP_XLO, ddo_pkg::OP_YLO:
                begin
                    acc_next = prod_reg[61:0] + ddo_pkg::ROUND_INC;
                end
                ddo_pkg::OP_XHI:
                begin
                    pos_x_next = pos_x_reg + acc_reg[61:30] + {prod_reg[29:0], 2'b00};
                end
                ddo_pkg::OP_YHI:
                begin
                    pos_y_next = pos_y_reg + acc_reg[61:30] + {prod_reg[29:0], 2'b00};
                    head_next  = head_reg + turn_reg;
                end
                default:
                begin
                    dl_next = dl_reg;
                end
            endcase
        end

        if (cfg_we)
        begin
            priority if (cfg_index == ddo_pkg::REG_LEFT_SCALE)
            begin
                lts_next = cfg_data;
            end
            else if (cfg_index == ddo_pkg::REG_RIGHT_SCALE)
            begin
                rts_next = cfg_data;
            end
            else if (cfg_index == ddo_pkg::REG_HEADING_GAIN)
            begin
                hg_next = cfg_data;
            end
            else
            begin
                hg_next = hg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lts_reg   <= ddo_pkg::SCALE_RESET;
            rts_reg   <= ddo_pkg::SCALE_RESET;
            hg_reg    <= ddo_pkg::SCALE_RESET;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            head_reg  <= ddo_pkg::HEADING_RESET;
        end
        else
        begin
            lts_reg   <= lts_next;
            rts_reg   <= rts_next;
            hg_reg    <= hg_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        flip_reg   <= flip_next;
        cos_reg    <= cos_next;
        sin_reg    <= sin_next;
        prod_reg   <= prod_next;
        dl_reg     <= dl_next;
        sum_reg    <= sum_next;
        diff_reg   <= diff_next;
        travel_reg <= travel_next;
        turn_reg   <= turn_next;
        acc_reg    <= acc_next;
    end

    assign pose_x       = $signed(pos_x_reg);
    assign pose_y       = $signed(pos_y_reg);
    assign pose_heading = $signed(head_reg);

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for differential_drive_odometry: a queue-fed driver, a result
// monitor and a bit-accurate pose tracker with a CORDIC of its own.
// Depends on ddo_pkg (register indexes, arctangent table) and the differential_drive_odometry RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CORDIC_STEPS           = 16;
    localparam int POSITION_FRACTION_BITS = 8;
    localparam int TRAVEL_SHIFT           = 17 - POSITION_FRACTION_BITS;
    localparam longint TRAVEL_ROUND       = longint'(1) << (TRAVEL_SHIFT - 1);
    localparam longint INCREMENT_ROUND    = longint'(1) << 29;
    localparam longint GAIN_SEED          = 652032874;
    localparam logic [31:0] QUARTER_BAU    = 32'h4000_0000;
    localparam logic [31:0] HALF_BAU       = 32'h8000_0000;
    localparam logic [31:0] HEADING_ORIGIN = 32'hC000_0000;
    localparam logic [31:0] SCALE_UNIT     = 32'h0001_0000;
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_REINIT = 1'b1;
    localparam int MAX_WAIT     = 12;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic        cmd;
        logic [15:0] left;
        logic [15:0] right;
    } request_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic signed [15:0] left_ticks = '0;
    logic signed [15:0] right_ticks = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic cfg_we = 1'b0;
    logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [31:0] left_scale = SCALE_UNIT;
    logic [31:0] right_scale = SCALE_UNIT;
    logic [31:0] heading_gain = SCALE_UNIT;
    logic [31:0] est_x = '0;
    logic [31:0] est_y = '0;
    logic [31:0] est_heading = HEADING_ORIGIN;

    request_t request_queue[$];
    pose_t    pose_expected[$];
    request_t next_request;
    pose_t    oldest_pose;

    bit req_taken = 1'b0;
    bit res_taken = 1'b0;
    bit result_seen = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int send_gap = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int mismatches = 0;

    differential_drive_odometry #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .POSITION_FRACTION_BITS(POSITION_FRACTION_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .left_ticks(left_ticks),
        .right_ticks(right_ticks),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pose_x(pose_x),
        .pose_y(pose_y),
        .pose_heading(pose_heading),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint arctan_step(input int i);
        return longint'({32'd0, ddo_pkg::atan_bau(ddo_pkg::ATAN_IDX_W'(i))});
    endfunction

    function automatic void unit_vector(input logic [31:0] angle, output longint c,
                                        output longint s);
        logic [31:0] shifted;
        logic [31:0] folded;
        logic flip;
        longint z, x, y, xs, ys;
        int i;
        shifted = angle + QUARTER_BAU;
        flip = shifted[31];
        folded = flip ? angle - HALF_BAU : angle;
        z = longint'($signed(folded));
        x = GAIN_SEED;
        y = 0;
        for (i = 0; i < CORDIC_STEPS; i = i + 1)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic pose_t advance_pose(input request_t r);
        longint dl, dr, travel, c, s;
        logic [63:0] diff, prod, px, py;
        pose_t p;
        if (r.cmd == CMD_REINIT)
        begin
            est_x = '0;
            est_y = '0;
            est_heading = HEADING_ORIGIN;
        end
        else
        begin
            // left wheel is mirror-mounted, so its raw ticks count backward
            dl = -(longint'($signed(r.left)) * longint'({32'd0, left_scale}));
            dr = longint'($signed(r.right)) * longint'({32'd0, right_scale});
            travel = (dl + dr + TRAVEL_ROUND) >>> TRAVEL_SHIFT;
            diff = dr - dl;
            prod = diff * {32'd0, heading_gain};
            unit_vector(est_heading, c, s);
            px = travel * c + INCREMENT_ROUND;
            py = travel * s + INCREMENT_ROUND;
            est_x = est_x + px[61:30];
            est_y = est_y + py[61:30];
            est_heading = est_heading + prod[63:32];
        end
        p.x = est_x;
        p.y = est_y;
        p.heading = est_heading;
        return p;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    function automatic logic [15:0] random_ticks();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            3: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(0, 600)) - 16'd300;
        endcase
    endfunction

    function automatic logic [31:0] random_register();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(256, 262144);
            4: return $urandom;
            default: return SCALE_UNIT;
        endcase
    endfunction

    task automatic queue_request(input logic cmd, input int left, input int right);
        request_t r;
        r.cmd = cmd;
        r.left = 16'(left);
        r.right = 16'(right);
        request_queue.push_back(r);
    endtask

    task automatic settle();
        while (request_queue.size() != 0 || in_valid || pose_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [ddo_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == ddo_pkg::REG_LEFT_SCALE)
            left_scale = value;
        else if (idx == ddo_pkg::REG_RIGHT_SCALE)
            right_scale = value;
        else if (idx == ddo_pkg::REG_HEADING_GAIN)
            heading_gain = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // acceptance, prediction, result check, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = in_valid && in_ready;
            res_taken = out_valid && out_ready;
            result_seen = out_valid;
            if (req_taken)
            begin
                next_request.cmd = command;
                next_request.left = left_ticks;
                next_request.right = right_ticks;
                pose_expected.push_back(advance_pose(next_request));
            end
            if (res_taken)
            begin
                if (pose_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected pose, expected none, actual %h %h %h",
                             $time, pose_x, pose_y, pose_heading);
                end
                else
                begin
                    oldest_pose = pose_expected.pop_front();
                    check_field("pose_x", oldest_pose.x, pose_x);
                    check_field("pose_y", oldest_pose.y, pose_y);
                    check_field("pose_heading", oldest_pose.heading, pose_heading);
                end
            end
            if (req_taken || res_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (request_queue.size() != 0 && send_gap == 0)
            begin
                next_request = request_queue.pop_front();
                command <= next_request.cmd;
                left_ticks <= next_request.left;
                right_ticks <= next_request.right;
                in_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
                send_gap = draw_wait(send_calm);
            end
            else
            begin
                in_valid <= 1'b0;
                if (send_gap != 0)
                    send_gap--;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                hold_cycles = draw_wait(recv_calm);
            end
            else if (result_seen && hold_cycles != 0)
            begin
                hold_cycles--;
            end
            out_ready <= (hold_cycles == 0);
        end
    end

    initial
    begin
        int phase;
        int n;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: origin, zero motion, field extremes, reinit with ticks
        queue_request(CMD_REINIT, 0, 0);
        queue_request(CMD_UPDATE, 0, 0);
        queue_request(CMD_UPDATE, -100, 100);
        queue_request(CMD_UPDATE, 32767, 32767);
        queue_request(CMD_UPDATE, -32768, -32768);
        queue_request(CMD_UPDATE, -32768, 32767);
        queue_request(CMD_UPDATE, 32767, -32768);
        queue_request(CMD_REINIT, 1234, -4321);
        settle();

        // quarter turns in place, straight legs between: every fold of the CORDIC
        write_register(ddo_pkg::REG_HEADING_GAIN, 32'h8000_0000);
        repeat (4)
        begin
            queue_request(CMD_UPDATE, -100, 100);
            queue_request(CMD_UPDATE, 16384, 16384);
        end
        queue_request(CMD_UPDATE, -100, 100);
        queue_request(CMD_UPDATE, -16384, -16384);
        settle();

        // largest scales and gain: positions and heading wrap
        write_register(ddo_pkg::REG_LEFT_SCALE, 32'hFFFF_FFFF);
        write_register(ddo_pkg::REG_RIGHT_SCALE, 32'hFFFF_FFFF);
        write_register(ddo_pkg::REG_HEADING_GAIN, 32'hFFFF_FFFF);
        queue_request(CMD_UPDATE, -32768, 32767);
        queue_request(CMD_UPDATE, 32767, -32768);
        queue_request(CMD_UPDATE, 32767, 32767);
        queue_request(CMD_UPDATE, -32768, -32768);
        settle();

        // zero scales and gain: nothing moves
        write_register(ddo_pkg::REG_LEFT_SCALE, '0);
        write_register(ddo_pkg::REG_RIGHT_SCALE, '0);
        write_register(ddo_pkg::REG_HEADING_GAIN, '0);
        queue_request(CMD_UPDATE, 1000, -2000);
        queue_request(CMD_UPDATE, -32768, 32767);
        queue_request(CMD_REINIT, 0, 0);
        settle();

        for (phase = 0; phase < 7; phase++)
        begin
            write_register(ddo_pkg::REG_LEFT_SCALE, random_register());
            write_register(ddo_pkg::REG_RIGHT_SCALE, random_register());
            write_register(ddo_pkg::REG_HEADING_GAIN, random_register());
            for (n = 0; n < 100; n++)
                queue_request(($urandom_range(0, 24) == 0) ? CMD_REINIT : CMD_UPDATE,
                              $signed(random_ticks()), $signed(random_ticks()));
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
